[hdl/mts_pkg.sv]
// mts_pkg: sizes, opcodes and widths shared by the min tracking stack.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package mts_pkg;

  // Number of entries the stack can hold.
  localparam int STACK_DEPTH = 128;

  // Entry address width and entry count width (the count must reach STACK_DEPTH).
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  // Payload widths fixed by the interface.
  localparam int DATA_W  = 32;
  localparam int DEPTH_W = 8;

  // Operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ADDR_W-1:0]        addr_t;

endpackage

[hdl/min_tracking_stack.sv]
// min_tracking_stack: stack of signed values that reports the running minimum.
// Depends on mts_pkg for sizes, opcodes and types.
`timescale 1ns / 1ps

//  Channel  Direction  Ports                                          Transfer when
//  in       input      in_valid, in_stall, in_opcode, in_push_value   in_valid && !in_stall
//  out      output     out_valid, out_stall, out_accepted,            out_valid && !out_stall
//                      out_depth_now, out_is_empty, out_current_min
//
// A push, a refused operation, and a pop that empties the stack go straight to the output register.
// A pop that leaves entries behind first passes through ST_POP_RD: the minimum of the new top
// entry comes from the registered read port of the running minimum memory.
// Reset (rst_n low, synchronous) empties the stack and drops any pending result.
// A result held under out_stall keeps the next transfer out, since the output
// register is the only place a result can wait.

module min_tracking_stack (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_opcode,
  input  logic signed [mts_pkg::DATA_W-1:0] in_push_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_accepted,
  output logic [mts_pkg::DEPTH_W-1:0]       out_depth_now,
  output logic                              out_is_empty,
  output logic signed [mts_pkg::DATA_W-1:0] out_current_min
);

  // Sequencer codes: ready for a new transfer, or waiting on a memory read.
  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_POP_RD  = 1'b1;

  logic state_r, state_nxt;

  // Entry count and the running minimum of the top entry, kept in registers
  // so that a push needs no memory read.
  mts_pkg::cnt_t  count_r, count_nxt;
  mts_pkg::data_t top_min_r, top_min_nxt;

  // Running minimum memory: each entry holds the minimum of itself and all
  // entries below it. The pushed values themselves are never read back, so
  // only the running minimum is stored.
  mts_pkg::data_t min_mem [mts_pkg::STACK_DEPTH];
  mts_pkg::data_t rd_data_r;
  mts_pkg::addr_t rd_addr;
  logic           rd_en;
  mts_pkg::addr_t wr_addr;
  logic           wr_en;
  mts_pkg::data_t wr_data;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_acc_r, out_acc_nxt;
  logic [mts_pkg::DEPTH_W-1:0]   out_depth_r, out_depth_nxt;
  logic                          out_empty_r, out_empty_nxt;
  mts_pkg::data_t                out_min_r, out_min_nxt;

  logic           in_xfer;
  logic           out_free;
  logic           is_full;
  logic           is_zero;
  mts_pkg::data_t push_min;
  mts_pkg::cnt_t  pop_count;

  // The output register is free when empty or being emptied this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_xfer  = in_valid && !in_stall;

  assign is_full   = (count_r == mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH));
  assign is_zero   = (count_r == '0);
  assign pop_count = count_r - mts_pkg::CNT_W'(1);

  // An equal value keeps the minimum below.
  assign push_min = (is_zero || (in_push_value < top_min_r)) ? in_push_value : top_min_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    top_min_nxt   = top_min_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_acc_nxt   = out_acc_r;
    out_depth_nxt = out_depth_r;
    out_empty_nxt = out_empty_r;
    out_min_nxt   = out_min_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[mts_pkg::ADDR_W-1:0];
    wr_data       = push_min;
    rd_en         = 1'b0;
    // The entry below the current top becomes the new top after a pop.
    rd_addr       = pop_count[mts_pkg::ADDR_W-1:0] - mts_pkg::ADDR_W'(1);

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_opcode == mts_pkg::OP_PUSH) begin
            if (!is_full) begin
              wr_en         = 1'b1;
              count_nxt     = count_r + mts_pkg::CNT_W'(1);
              top_min_nxt   = push_min;
              out_acc_nxt   = 1'b1;
              out_depth_nxt = mts_pkg::DEPTH_W'(count_r + mts_pkg::CNT_W'(1));
              out_empty_nxt = 1'b0;
              out_min_nxt   = push_min;
            end else begin
              out_acc_nxt   = 1'b0;
              out_depth_nxt = mts_pkg::DEPTH_W'(count_r);
              out_empty_nxt = 1'b0;
              out_min_nxt   = top_min_r;
            end
            out_valid_nxt = 1'b1;
          end else begin
            if (is_zero) begin
              // Pop from an empty stack is refused.
              out_acc_nxt   = 1'b0;
              out_depth_nxt = '0;
              out_empty_nxt = 1'b1;
              out_min_nxt   = '0;
              out_valid_nxt = 1'b1;
            end else if (pop_count == '0) begin
              count_nxt     = pop_count;
              out_acc_nxt   = 1'b1;
              out_depth_nxt = '0;
              out_empty_nxt = 1'b1;
              out_min_nxt   = '0;
              out_valid_nxt = 1'b1;
            end else begin
              // Fetch the new top minimum; ST_POP_RD writes the result from the read register.
              rd_en         = 1'b1;
              count_nxt     = pop_count;
              state_nxt     = ST_POP_RD;
            end
          end
        end
      end
      ST_POP_RD: begin
        // The output register was free at acceptance and has stayed empty.
        top_min_nxt   = rd_data_r;
        out_acc_nxt   = 1'b1;
        out_depth_nxt = mts_pkg::DEPTH_W'(count_r);
        out_empty_nxt = 1'b0;
        out_min_nxt   = rd_data_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      min_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= min_mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    top_min_r   <= top_min_nxt;
    out_acc_r   <= out_acc_nxt;
    out_depth_r <= out_depth_nxt;
    out_empty_r <= out_empty_nxt;
    out_min_r   <= out_min_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_depth_now   = out_depth_r;
  assign out_is_empty    = out_empty_r;
  assign out_current_min = out_min_r;

endmodule
